// ----- hdl/pad_pkg.sv -----
// ----------------------------------------------------------------------------
// pad_pkg
// shared types and constants of the pilot aided phase derotator
// ----------------------------------------------------------------------------
package pad_pkg;

  localparam int ACC_W       = 40;
  localparam int VX_W        = 44;
  localparam int ANG_W       = 34;
  localparam int RX_W        = 33;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [14:0]             AMP_RESET    = 15'd500;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;
  localparam logic signed [RX_W-1:0]  GAIN_Q30     = 33'sd652032874;

  typedef enum logic [1:0] {
    CMD_PRE,
    CMD_PRE_LAST,
    CMD_PAY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               clear;
    logic               neg;
    logic               last;
    logic signed [15:0] chip_i;
    logic signed [15:0] chip_q;
  } cmd_t;

  function automatic logic [31:0] atan_ent(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/pilot_aided_phase_derotator_core.sv -----
// Pilot aided phase derotator. Chips enter through push/full; the front stage
// takes one chip per cycle while the queue is not full into a four deep queue
// and the back stage works them off one at a time. Each preamble or payload
// chip is multiplied, then accumulated or rounded; the round waits while the
// output register is full. The last preamble chip also runs the vectoring and
// rotation cordic, both iterating one step per cycle on one shared sequencer
// (vectoring is skipped when the correlation is zero); the queue buffers chips
// during this pause and full holds off further pushes. Results wait in one output
// register read through empty/pop. The amplitude register sits at byte address 0.
// ----------------------------------------------------------------------------
// pilot_aided_phase_derotator_core
// top level: configuration register, front stage, queue and back stage
// ----------------------------------------------------------------------------
module pilot_aided_phase_derotator_core #(
  parameter int PREAMBLE_LEN = 128,
  parameter int PAYLOAD_LEN  = 64,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_chip_i,
  input  logic signed [15:0] in_chip_q,
  input  logic               in_start_frame,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic signed [15:0] out_phase_estimate,
  output logic               out_last_of_payload,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pad_pkg::*;

  logic [14:0] amp_r;
  logic        q_push, q_full, q_rd, q_empty;
  cmd_t        q_wdata, q_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {17'd0, amp_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= AMP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      amp_r <= pwdata[14:0];
    end
  end

  pad_front #(
    .PREAMBLE_LEN(PREAMBLE_LEN),
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_chip_i     (in_chip_i),
    .in_chip_q     (in_chip_q),
    .in_start_frame(in_start_frame),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_wdata)
  );

  pad_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_push),
    .wr_data(q_wdata),
    .q_full (q_full),
    .rd_en  (q_rd),
    .rd_data(q_rdata),
    .q_empty(q_empty)
  );

  pad_back #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .amp                (amp_r),
    .q_empty            (q_empty),
    .q_data             (q_rdata),
    .q_rd               (q_rd),
    .empty              (empty),
    .pop                (pop),
    .out_i              (out_i),
    .out_q              (out_q),
    .out_phase_estimate (out_phase_estimate),
    .out_last_of_payload(out_last_of_payload)
  );

  a_amp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(psel && penable && pwrite) |=> $stable(amp_r)) else $error("amplitude changed");
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_empty) else $error("queue full and empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");

endmodule

// ----- hdl/pad_front.sv -----
// ----------------------------------------------------------------------------
// pad_front
// takes chip requests, tracks frame position and classifies each chip
// ----------------------------------------------------------------------------
module pad_front #(
  parameter int PREAMBLE_LEN = 128,
  parameter int PAYLOAD_LEN  = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_chip_i,
  input  logic signed [15:0] in_chip_q,
  input  logic               in_start_frame,
  input  logic               q_full,
  output logic               q_push,
  output pad_pkg::cmd_t      q_data
);
  import pad_pkg::*;

  localparam int POS_W = $clog2(PREAMBLE_LEN + PAYLOAD_LEN + 1);
  localparam logic [POS_W-1:0] PRE_END  = POS_W'(PREAMBLE_LEN);
  localparam logic [POS_W-1:0] PRE_LAST = POS_W'(PREAMBLE_LEN - 1);
  localparam logic [POS_W-1:0] PAY_LAST = POS_W'(PREAMBLE_LEN + PAYLOAD_LEN - 1);
  localparam logic [POS_W-1:0] PAT_LEN  = POS_W'(64);

  logic             in_frame_r, in_frame_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pos_eff;
  logic             frame_eff;
  logic             accept;

  assign full      = q_full;
  assign accept    = push & ~q_full;
  assign pos_eff   = in_start_frame ? '0 : pos_r;
  assign frame_eff = in_start_frame | in_frame_r;
  assign q_push    = accept & frame_eff;

  always_comb begin
    q_data.chip_i = in_chip_i;
    q_data.chip_q = in_chip_q;
    q_data.clear  = in_start_frame;
    q_data.neg    = (pos_eff < PAT_LEN) & (^pos_eff[5:0]);
    q_data.last   = (pos_eff == PAY_LAST);
    if (pos_eff < PRE_END) begin
      q_data.kind = (pos_eff == PRE_LAST) ? CMD_PRE_LAST : CMD_PRE;
    end else begin
      q_data.kind = CMD_PAY;
    end
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    pos_nxt      = pos_r;
    if (accept && frame_eff) begin
      if (pos_eff == PAY_LAST) begin
        in_frame_nxt = 1'b0;
        pos_nxt      = '0;
      end else begin
        in_frame_nxt = 1'b1;
        pos_nxt      = pos_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      pos_r      <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      pos_r      <= pos_nxt;
    end
  end

  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> pos_r == '0) else $error("position left over outside a frame");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> pos_r <= PAY_LAST) else $error("position beyond frame");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_data.last |=> !in_frame_r) else $error("frame not closed");

endmodule

// ----- hdl/pad_queue.sv -----
// ----------------------------------------------------------------------------
// pad_queue
// short queue of classified chips between front and back
// ----------------------------------------------------------------------------
module pad_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pad_pkg::cmd_t wr_data,
  output logic          q_full,
  input  logic          rd_en,
  output pad_pkg::cmd_t rd_data,
  output logic          q_empty
);
  import pad_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en & ~q_full;
  assign do_rd   = rd_en & ~q_empty;
  assign rd_data = mem[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPTR_W+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (QPTR_W+1)'(QUEUE_DEPTH)) |-> wp_r == rp_r)
    else $error("queue pointers out of step");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_wr && !do_rd |=> cnt_r == $past(cnt_r) + 1'b1) else $error("lost write");

endmodule

// ----- hdl/pad_back.sv -----
// ----------------------------------------------------------------------------
// pad_back
// correlation, cordic phase estimate and payload derotation
// ----------------------------------------------------------------------------
module pad_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [14:0]        amp,
  input  logic               q_empty,
  input  pad_pkg::cmd_t      q_data,
  output logic               q_rd,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_i,
  output logic signed [15:0] out_q,
  output logic signed [15:0] out_phase_estimate,
  output logic               out_last_of_payload
);
  import pad_pkg::*;

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ACC, ST_VPRE, ST_VEC, ST_PHASE, ST_ROT, ST_FIN, ST_POUT
  } state_t;

  state_t                   state_r;
  cmd_kind_t                kind_r;
  logic                     clear_r, last_r, zero_r;
  logic signed [33:0]       pa_r, pb_r, pc_r, pd_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [VX_W-1:0]   x_r, y_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic signed [RX_W-1:0]   cx_r, cy_r;
  logic [STEP_W-1:0]        step_r;
  logic signed [16:0]       cos_r, sin_r;
  logic signed [15:0]       phase_r;
  logic                     ov_r;
  logic signed [15:0]       oi_r, oq_r, oph_r;
  logic                     olast_r;

  logic signed [16:0]       m_a0, m_a1, m_b0, m_b1, sum_iq, dif_iq, pref, ci17, cq17;
  logic signed [ANG_W-1:0]  atan_v;
  logic signed [VX_W-1:0]   xs, ys, re44, im44;
  logic signed [RX_W-1:0]   cxs, cys;
  logic signed [15:0]       ph_new;
  logic signed [ANG_W-1:0]  t0;
  logic                     out_wr;

  function automatic logic signed [15:0] round_sat(input logic signed [34:0] v);
    logic        neg;
    logic [34:0] mag;
    logic [34:0] q;
    logic [15:0] r;
    neg = v[34];
    mag = neg ? 35'(-v) : 35'(v);
    q   = (mag + 35'd16384) >> 15;
    if (!neg) begin
      r = (q > 35'd32767) ? 16'h7FFF : q[15:0];
    end else begin
      r = (q > 35'd32768) ? 16'h8000 : 16'(-q[15:0]);
    end
    return r;
  endfunction

  function automatic logic signed [16:0] round_clamp(input logic signed [RX_W-1:0] v);
    logic signed [RX_W:0] s;
    logic signed [RX_W:0] r;
    logic signed [16:0]   c;
    s = {v[RX_W-1], v} + (RX_W+1)'(16384);
    r = s >>> 15;
    if (r > (RX_W+1)'(32768)) begin
      c = 17'sd32768;
    end else if (r < -(RX_W+1)'(32768)) begin
      c = -17'sd32768;
    end else begin
      c = r[16:0];
    end
    return c;
  endfunction

  assign q_rd   = (state_r == ST_IDLE) & ~q_empty;
  assign out_wr = (state_r == ST_POUT) & (~ov_r | pop);

  always_comb begin
    ci17   = {q_data.chip_i[15], q_data.chip_i};
    cq17   = {q_data.chip_q[15], q_data.chip_q};
    sum_iq = ci17 + cq17;
    dif_iq = cq17 - ci17;
    pref   = q_data.neg ? -$signed({2'b00, amp}) : $signed({2'b00, amp});
    if (q_data.kind == CMD_PAY) begin
      m_a0 = ci17;   m_a1 = cos_r;
      m_b0 = cq17;   m_b1 = sin_r;
    end else begin
      m_a0 = sum_iq; m_a1 = pref;
      m_b0 = dif_iq; m_b1 = pref;
    end
    atan_v = $signed({2'b00, atan_ent(5'(step_r))});
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
    cxs    = cx_r >>> step_r;
    cys    = cy_r >>> step_r;
    re44   = {{(VX_W-ACC_W){acc_re_r[ACC_W-1]}}, acc_re_r};
    im44   = {{(VX_W-ACC_W){acc_im_r[ACC_W-1]}}, acc_im_r};
    ph_new = zero_r ? 16'sd0 : $signed(16'((ang_r + ANG_W'(32768)) >>> 16));
    t0     = {{2{ph_new[15]}}, ph_new, 16'h0000};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_re_r <= '0;
      acc_im_r <= '0;
      cos_r    <= 17'sd32768;
      sin_r    <= '0;
      phase_r  <= '0;
      ov_r     <= 1'b0;
      step_r   <= '0;
    end else begin
      if (out_wr) begin
        ov_r <= 1'b1;
      end else if (pop) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            kind_r  <= q_data.kind;
            clear_r <= q_data.clear;
            last_r  <= q_data.last;
            pa_r    <= m_a0 * m_a1;
            pb_r    <= m_b0 * m_b1;
            pc_r    <= cq17 * cos_r;
            pd_r    <= ci17 * sin_r;
            state_r <= (q_data.kind == CMD_PAY) ? ST_POUT : ST_ACC;
          end
        end
        ST_ACC: begin
          acc_re_r <= (clear_r ? '0 : acc_re_r) + {{(ACC_W-34){pa_r[33]}}, pa_r};
          acc_im_r <= (clear_r ? '0 : acc_im_r) + {{(ACC_W-34){pb_r[33]}}, pb_r};
          state_r  <= (kind_r == CMD_PRE_LAST) ? ST_VPRE : ST_IDLE;
        end
        ST_VPRE: begin
          zero_r <= (acc_re_r == '0) && (acc_im_r == '0);
          step_r <= '0;
          if (re44 < 0) begin
            if (im44 >= 0) begin
              x_r <= im44; y_r <= -re44; ang_r <= QUARTER_TURN;
            end else begin
              x_r <= -im44; y_r <= re44; ang_r <= -QUARTER_TURN;
            end
          end else begin
            x_r <= re44; y_r <= im44; ang_r <= '0;
          end
          state_r <= ((acc_re_r == '0) && (acc_im_r == '0)) ? ST_PHASE : ST_VEC;
        end
        ST_VEC: begin
          if (y_r >= 0) begin
            x_r <= x_r + ys; y_r <= y_r - xs; ang_r <= ang_r + atan_v;
          end else begin
            x_r <= x_r - ys; y_r <= y_r + xs; ang_r <= ang_r - atan_v;
          end
          if (step_r == STEP_LAST) begin
            state_r <= ST_PHASE;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_PHASE: begin
          phase_r <= ph_new;
          step_r  <= '0;
          if (t0 > QUARTER_TURN) begin
            cx_r <= '0; cy_r <= GAIN_Q30; ang_r <= t0 - QUARTER_TURN;
          end else if (t0 < -QUARTER_TURN) begin
            cx_r <= '0; cy_r <= -GAIN_Q30; ang_r <= t0 + QUARTER_TURN;
          end else begin
            cx_r <= GAIN_Q30; cy_r <= '0; ang_r <= t0;
          end
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          if (ang_r >= 0) begin
            cx_r <= cx_r - cys; cy_r <= cy_r + cxs; ang_r <= ang_r - atan_v;
          end else begin
            cx_r <= cx_r + cys; cy_r <= cy_r - cxs; ang_r <= ang_r + atan_v;
          end
          if (step_r == STEP_LAST) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        ST_FIN: begin
          cos_r   <= round_clamp(cx_r);
          sin_r   <= round_clamp(cy_r);
          state_r <= ST_IDLE;
        end
        ST_POUT: begin
          if (out_wr) begin
            oi_r    <= round_sat(35'(pa_r) + 35'(pb_r));
            oq_r    <= round_sat(35'(pc_r) - 35'(pd_r));
            oph_r   <= phase_r;
            olast_r <= last_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign empty               = ~ov_r;
  assign out_i               = oi_r;
  assign out_q               = oq_r;
  assign out_phase_estimate  = oph_r;
  assign out_last_of_payload = olast_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VEC || state_r == ST_ROT) |-> step_r <= STEP_LAST)
    else $error("cordic step out of range");
  a_pout_kind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POUT |-> kind_r == CMD_PAY) else $error("payload state without payload");
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == ST_FIN |-> (cos_r <= 17'sd32768 && cos_r >= -17'sd32768))
    else $error("cos out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !pop |=> ov_r && $stable(oi_r)) else $error("result overwritten");

endmodule
